>>> sv/efp_pkg.sv
// Shared constants, types and helper functions for the escape-time fractal pixel block.
// No dependencies; imported by the controller, the datapath and the top level.
package efp_pkg;

  localparam int FRAC_BITS      = 24;
  localparam int COORD_W        = 32;
  localparam int IDX_W          = 10;
  localparam int STEP_W         = 25;
  localparam int RAD_W          = 31;
  localparam int ITER_W         = 12;
  localparam int MAX_ITER_LIMIT = 4095;
  localparam int PROD_W         = 2 * COORD_W;
  localparam int SQ_W           = PROD_W - FRAC_BITS;
  localparam int XY_W           = SQ_W + 1;
  localparam int ACC_W          = XY_W + 1;
  localparam int OFF_W          = IDX_W + STEP_W;
  localparam int REG_W          = 32;
  localparam int ADDR_W         = 5;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_STEP_X   = 3'd2;
  localparam logic [2:0] REG_STEP_Y   = 3'd3;
  localparam logic [2:0] REG_RADIUS   = 3'd4;
  localparam logic [2:0] REG_MAX_ITER = 3'd5;

  typedef struct packed {
    logic capture;
    logic scale;
    logic point;
    logic mul;
    logic upd;
    logic finish;
  } efp_cmd_t;

  typedef struct packed {
    logic limit_zero;
    logic escape;
    logic last;
  } efp_status_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v[ACC_W-1:COORD_W-1] == '0 || v[ACC_W-1:COORD_W-1] == '1) begin
      r = v[COORD_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [ITER_W-1:0] eff_limit(input logic [ITER_W-1:0] m);
    logic [ITER_W-1:0] r;
    if (32'(m) > MAX_ITER_LIMIT) begin
      r = ITER_W'(MAX_ITER_LIMIT);
    end else begin
      r = m;
    end
    return r;
  endfunction

endpackage

>>> sv/escape_time_fractal_pixel.sv
// Escape-time fractal pixel engine: one pixel at a time, R iterations tested (the count, plus
// one when the point escapes). Each iteration forms the three 32x32 products, then the test and z update.
// The sequencer returns to idle when the result is registered and can take the next pixel while the result still waits.
// Synchronous active-high reset returns the sequencer to idle, empties the result register
// and loads the configuration registers with their defaults.
module escape_time_fractal_pixel (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pixel_valid,
  output logic                               pixel_ready,
  input  logic [efp_pkg::IDX_W-1:0]          column,
  input  logic [efp_pkg::IDX_W-1:0]          row,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic [efp_pkg::ITER_W-1:0]         iteration_count,
  output logic                               inside_res,
  output logic [efp_pkg::IDX_W-1:0]          pixel_column,
  output logic [efp_pkg::IDX_W-1:0]          pixel_row,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [efp_pkg::ADDR_W-1:0]         paddr,
  input  logic [efp_pkg::REG_W-1:0]          pwdata,
  output logic [efp_pkg::REG_W-1:0]          prdata,
  output logic                               pready
);
  import efp_pkg::*;

  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  logic        [STEP_W-1:0]  step_x;
  logic        [STEP_W-1:0]  step_y;
  logic        [RAD_W-1:0]   escape_radius_sq;
  logic        [ITER_W-1:0]  max_iter;

  efp_cmd_t                  cmd;
  efp_status_t               status;
  logic                      out_free;
  logic        [ITER_W-1:0]  count;
  logic                      in_set;
  logic        [IDX_W-1:0]   col_q;
  logic        [IDX_W-1:0]   row_q;
  logic                      cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x         <= -32'sd41943040;
      origin_y         <= -32'sd25165824;
      step_x           <= STEP_W'(49152);
      step_y           <= STEP_W'(49152);
      escape_radius_sq <= RAD_W'(67108864);
      max_iter         <= ITER_W'(256);
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_ORIGIN_X: origin_x         <= signed'(pwdata);
        REG_ORIGIN_Y: origin_y         <= signed'(pwdata);
        REG_STEP_X:   step_x           <= pwdata[STEP_W-1:0];
        REG_STEP_Y:   step_y           <= pwdata[STEP_W-1:0];
        REG_RADIUS:   escape_radius_sq <= pwdata[RAD_W-1:0];
        REG_MAX_ITER: max_iter         <= pwdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_ORIGIN_X: prdata = unsigned'(origin_x);
      REG_ORIGIN_Y: prdata = unsigned'(origin_y);
      REG_STEP_X:   prdata = REG_W'(step_x);
      REG_STEP_Y:   prdata = REG_W'(step_y);
      REG_RADIUS:   prdata = REG_W'(escape_radius_sq);
      REG_MAX_ITER: prdata = REG_W'(max_iter);
      default:      prdata = '0;
    endcase
  end

  assign out_free = !result_valid || result_ready;

  efp_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .out_free    (out_free),
    .status      (status),
    .cmd         (cmd)
  );

  efp_datapath u_datapath (
    .clk              (clk),
    .cmd              (cmd),
    .status           (status),
    .origin_x         (origin_x),
    .origin_y         (origin_y),
    .step_x           (step_x),
    .step_y           (step_y),
    .escape_radius_sq (escape_radius_sq),
    .max_iter         (max_iter),
    .column           (column),
    .row              (row),
    .count            (count),
    .in_set           (in_set),
    .col_q            (col_q),
    .row_q            (row_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.finish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      iteration_count <= count;
      inside_res      <= in_set;
      pixel_column    <= col_q;
      pixel_row       <= row_q;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel_ready |=> !pixel_ready)
    else $error("sequencer still ready after taking a pixel request");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> result_valid)
    else $error("finished pixel did not reach the result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!result_valid || result_ready))
    else $error("result register overwritten while its request was pending");

endmodule

>>> sv/efp_ctrl.sv
// Sequencing state machine for the fractal pixel block.
// Depends on efp_pkg for the command and status structs.
module efp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  output logic                pixel_ready,
  input  logic                out_free,
  input  efp_pkg::efp_status_t status,
  output efp_pkg::efp_cmd_t    cmd
);
  import efp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_POINT,
    S_MUL,
    S_UPD,
    S_FINISH
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (pixel_valid) state <= S_SCALE;
        end
        S_SCALE: state <= S_POINT;
        S_POINT: begin
          if (status.limit_zero) state <= S_FINISH;
          else state <= S_MUL;
        end
        S_MUL: state <= S_UPD;
        S_UPD: begin
          if (status.escape || status.last) state <= S_FINISH;
          else state <= S_MUL;
        end
        S_FINISH: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    pixel_ready = (state == S_IDLE);
    cmd.capture = (state == S_IDLE) && pixel_valid;
    cmd.scale   = (state == S_SCALE);
    cmd.point   = (state == S_POINT);
    cmd.mul     = (state == S_MUL);
    cmd.upd     = (state == S_UPD);
    cmd.finish  = (state == S_FINISH) && out_free;
  end

endmodule

>>> sv/efp_datapath.sv
// Arithmetic datapath: point set-up, the three 32x32 products and the iteration update.
// Depends on efp_pkg for widths, saturation and the command and status structs.
module efp_datapath (
  input  logic                                  clk,
  input  efp_pkg::efp_cmd_t                     cmd,
  output efp_pkg::efp_status_t                  status,
  input  logic signed [efp_pkg::COORD_W-1:0]    origin_x,
  input  logic signed [efp_pkg::COORD_W-1:0]    origin_y,
  input  logic        [efp_pkg::STEP_W-1:0]     step_x,
  input  logic        [efp_pkg::STEP_W-1:0]     step_y,
  input  logic        [efp_pkg::RAD_W-1:0]      escape_radius_sq,
  input  logic        [efp_pkg::ITER_W-1:0]     max_iter,
  input  logic        [efp_pkg::IDX_W-1:0]      column,
  input  logic        [efp_pkg::IDX_W-1:0]      row,
  output logic        [efp_pkg::ITER_W-1:0]     count,
  output logic                                  in_set,
  output logic        [efp_pkg::IDX_W-1:0]      col_q,
  output logic        [efp_pkg::IDX_W-1:0]      row_q
);
  import efp_pkg::*;

  logic        [OFF_W-1:0]   off_x;
  logic        [OFF_W-1:0]   off_y;
  logic signed [COORD_W-1:0] cx;
  logic signed [COORD_W-1:0] cy;
  logic signed [COORD_W-1:0] x;
  logic signed [COORD_W-1:0] y;
  logic signed [PROD_W-1:0]  px;
  logic signed [PROD_W-1:0]  py;
  logic signed [PROD_W-1:0]  pxy;

  logic signed [SQ_W-1:0]    sq_x;
  logic signed [SQ_W-1:0]    sq_y;
  logic signed [XY_W-1:0]    xy2;
  logic signed [ACC_W-1:0]   mag;
  logic signed [ACC_W-1:0]   radius_ext;
  logic signed [ACC_W-1:0]   re_sum;
  logic signed [ACC_W-1:0]   im_sum;
  logic signed [ACC_W-1:0]   cx_sum;
  logic signed [ACC_W-1:0]   cy_sum;
  logic        [ITER_W-1:0]  count_inc;
  logic        [ITER_W-1:0]  limit;

  always_comb begin
    sq_x       = px[PROD_W-1:FRAC_BITS];
    sq_y       = py[PROD_W-1:FRAC_BITS];
    xy2        = pxy[PROD_W-1:FRAC_BITS-1];
    mag        = ACC_W'(sq_x) + ACC_W'(sq_y);
    radius_ext = signed'(ACC_W'(escape_radius_sq));
    re_sum     = ACC_W'(sq_x) - ACC_W'(sq_y) + ACC_W'(cx);
    im_sum     = ACC_W'(xy2) + ACC_W'(cy);
    cx_sum     = ACC_W'(origin_x) + signed'(ACC_W'(off_x));
    cy_sum     = ACC_W'(origin_y) + signed'(ACC_W'(off_y));
    count_inc  = count + ITER_W'(1);
    limit      = eff_limit(max_iter);

    status.escape     = (mag > radius_ext);
    status.last       = (count_inc == limit);
    status.limit_zero = (limit == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_q <= column;
      row_q <= row;
    end
    if (cmd.scale) begin
      off_x <= OFF_W'(col_q) * OFF_W'(step_x);
      off_y <= OFF_W'(row_q) * OFF_W'(step_y);
    end
    if (cmd.point) begin
      cx     <= sat_coord(cx_sum);
      cy     <= sat_coord(cy_sum);
      x      <= sat_coord(cx_sum);
      y      <= sat_coord(cy_sum);
      count  <= '0;
      in_set <= 1'b1;
    end
    if (cmd.mul) begin
      px  <= PROD_W'(x) * PROD_W'(x);
      py  <= PROD_W'(y) * PROD_W'(y);
      pxy <= PROD_W'(x) * PROD_W'(y);
    end
    if (cmd.upd) begin
      if (status.escape) begin
        in_set <= 1'b0;
      end else begin
        count <= count_inc;
        x     <= sat_coord(re_sum);
        y     <= sat_coord(im_sum);
      end
    end
  end

endmodule
